/* hdl/lei_pkg.sv */
// lorenz euler integrator: shared types, register map and the step program
`default_nettype none
package lei_pkg;

  // fixed formats of the register fields
  localparam int CFG_W       = 28;
  localparam int CFG_FRAC    = 20;
  localparam int DT_W        = 16;
  localparam int DT_FRAC     = 24;
  localparam int STEP_W      = 16;
  localparam int OUT_COORD_W = 32;
  localparam int MUL_DIGIT_W = 16;

  // register map, index = paddr[4:2]
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RHO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS = 3'd5;

  localparam logic [CFG_W-1:0]  SIGMA_RST = 28'd10485760;
  localparam logic [CFG_W-1:0]  RHO_RST   = 28'd29360128;
  localparam logic [CFG_W-1:0]  BETA_RST  = 28'd2796134;
  localparam logic [DT_W-1:0]   DT_RST    = 16'd16777;
  localparam logic [CFG_W-1:0]  START_RST = 28'd1048576;
  localparam logic [STEP_W-1:0] STEPS_RST = 16'd50000;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_SUB,
    OP_ADD,
    OP_MUL,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    SEL_X,
    SEL_Y,
    SEL_Z,
    SEL_T0,
    SEL_T1,
    SEL_T2,
    SEL_T3,
    SEL_SG,
    SEL_RH,
    SEL_BT,
    SEL_DT
  } sel_t;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_WAIT = 4'd0;

  typedef struct packed {
    op_t             op;
    sel_t            dst;
    sel_t            src_a;
    sel_t            src_b;
    logic            dt_shift;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic dt_shift;
  } mul_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } mul_sts_t;

  // one euler step: derivatives first, then the three updates
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{OP_WAIT, SEL_X,  SEL_X,  SEL_X,  1'b0, PC_WAIT};
      4'd1:    w = '{OP_SUB,  SEL_T0, SEL_Y,  SEL_X,  1'b0, PC_WAIT};
      4'd2:    w = '{OP_MUL,  SEL_T0, SEL_SG, SEL_T0, 1'b0, PC_WAIT};
      4'd3:    w = '{OP_SUB,  SEL_T1, SEL_RH, SEL_Z,  1'b0, PC_WAIT};
      4'd4:    w = '{OP_MUL,  SEL_T1, SEL_X,  SEL_T1, 1'b0, PC_WAIT};
      4'd5:    w = '{OP_SUB,  SEL_T1, SEL_T1, SEL_Y,  1'b0, PC_WAIT};
      4'd6:    w = '{OP_MUL,  SEL_T2, SEL_X,  SEL_Y,  1'b0, PC_WAIT};
      4'd7:    w = '{OP_MUL,  SEL_T3, SEL_BT, SEL_Z,  1'b0, PC_WAIT};
      4'd8:    w = '{OP_SUB,  SEL_T2, SEL_T2, SEL_T3, 1'b0, PC_WAIT};
      4'd9:    w = '{OP_MUL,  SEL_T0, SEL_DT, SEL_T0, 1'b1, PC_WAIT};
      4'd10:   w = '{OP_ADD,  SEL_X,  SEL_X,  SEL_T0, 1'b0, PC_WAIT};
      4'd11:   w = '{OP_MUL,  SEL_T1, SEL_DT, SEL_T1, 1'b1, PC_WAIT};
      4'd12:   w = '{OP_ADD,  SEL_Y,  SEL_Y,  SEL_T1, 1'b0, PC_WAIT};
      4'd13:   w = '{OP_MUL,  SEL_T2, SEL_DT, SEL_T2, 1'b1, PC_WAIT};
      4'd14:   w = '{OP_ADD,  SEL_Z,  SEL_Z,  SEL_T2, 1'b0, PC_WAIT};
      4'd15:   w = '{OP_EMIT, SEL_X,  SEL_X,  SEL_X,  1'b0, PC_WAIT};
      default: w = '{OP_WAIT, SEL_X,  SEL_X,  SEL_X,  1'b0, PC_WAIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* hdl/lorenz_euler_integrator.sv */
// lorenz euler integrator: one explicit euler step of the lorenz system per input word
// in_tready is high only while the step program waits, so a new word is taken only after the
// previous step has been emitted; the emit stalls while a held word is not taken by out_tready
// the multiplier is shared: seven products per step, 16 bits of one operand per cycle after
// a load step and before a round/saturate step; adds and subtracts use the saturating alu
// reset: registers take their default values, the point is 1.0 on every axis, step count zero
`default_nettype none
module lorenz_euler_integrator import lei_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 20
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // in_tdata: [0] restart, [7:1] zero
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [7:0]           in_tdata,
  // out_tdata: [31:0] coord_x, [63:32] coord_y, [95:64] coord_z, [111:96] step_index
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [111:0]         out_tdata,
  output logic                 out_tlast,
  input  wire                  cfg_psel,
  input  wire                  cfg_penable,
  input  wire                  cfg_pwrite,
  input  wire  [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire  [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int CW      = COORD_WIDTH;
  localparam int CFG_LSH = (FRAC_BITS >= CFG_FRAC) ? FRAC_BITS - CFG_FRAC : 0;
  localparam int CFG_RSH = (FRAC_BITS < CFG_FRAC) ? CFG_FRAC - FRAC_BITS : 0;
  localparam int EXT_W   = CFG_W + CFG_LSH;
  localparam int SAT_W   = ((EXT_W > CW) ? EXT_W : CW) + 1;

  localparam logic [CW-1:0] C_MAX   = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] C_MIN   = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ONE_RST = CW'(1) << FRAC_BITS;

  // configuration registers
  logic [CFG_W-1:0]  sigma_r, rho_r, beta_r, start_r;
  logic [DT_W-1:0]   dt_r;
  logic [STEP_W-1:0] steps_r;

  // datapath
  logic signed [CW-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic signed [CW-1:0] t0_r, t1_r, t2_r, t3_r, t0_nxt, t1_nxt, t2_nxt, t3_nxt;
  logic [STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [PC_W-1:0]      pc_r, pc_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [111:0]         out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;

  uword_t               uw;
  logic signed [CW-1:0] sg_v, rh_v, bt_v, s0_v, dt_v;
  logic signed [CW-1:0] opa, opb, alu_res, wr_val, mul_res;
  logic [CW:0]          alu_sum;
  logic                 accept, reload, emit_go, adv, wr;
  logic [STEP_W-1:0]    len, cnt_inc;
  logic                 cfg_wr;
  mul_ctl_t             mul_ctl;
  mul_sts_t             mul_sts;

  // register field to coordinate format, floor on right shift, saturate
  function automatic logic signed [CW-1:0] cfg_to_coord(input logic signed [CFG_W-1:0] raw);
    logic signed [SAT_W-1:0] v;
    logic [SAT_W-CW:0]       hi;
    v  = (SAT_W'(raw) <<< CFG_LSH) >>> CFG_RSH;
    hi = v[SAT_W-1:CW-1];
    if ((&hi) || !(|hi)) begin
      return v[CW-1:0];
    end
    return v[SAT_W-1] ? C_MIN : C_MAX;
  endfunction

  assign sg_v = cfg_to_coord(sigma_r);
  assign rh_v = cfg_to_coord(rho_r);
  assign bt_v = cfg_to_coord(beta_r);
  assign s0_v = cfg_to_coord(start_r);
  assign dt_v = CW'(dt_r);

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= SIGMA_RST;
      rho_r   <= RHO_RST;
      beta_r  <= BETA_RST;
      dt_r    <= DT_RST;
      start_r <= START_RST;
      steps_r <= STEPS_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[CFG_ADDR_W-1:2])
        REG_SIGMA: sigma_r <= cfg_pwdata[CFG_W-1:0];
        REG_RHO:   rho_r   <= cfg_pwdata[CFG_W-1:0];
        REG_BETA:  beta_r  <= cfg_pwdata[CFG_W-1:0];
        REG_DT:    dt_r    <= cfg_pwdata[DT_W-1:0];
        REG_START: start_r <= cfg_pwdata[CFG_W-1:0];
        REG_STEPS: steps_r <= cfg_pwdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[CFG_ADDR_W-1:2])
      REG_SIGMA: cfg_prdata = 32'(sigma_r);
      REG_RHO:   cfg_prdata = 32'(rho_r);
      REG_BETA:  cfg_prdata = 32'(beta_r);
      REG_DT:    cfg_prdata = 32'(dt_r);
      REG_START: cfg_prdata = 32'(start_r);
      REG_STEPS: cfg_prdata = 32'(steps_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // sequencer
  assign uw        = ucode(pc_r);
  assign in_tready = (uw.op == OP_WAIT);
  assign accept    = in_tvalid && in_tready;
  assign len       = (steps_r == '0) ? STEP_W'(1) : steps_r;
  assign reload    = in_tdata[0] || (cnt_r >= len);
  assign emit_go   = (uw.op == OP_EMIT) && (!out_valid_r || out_tready);
  assign cnt_inc   = cnt_r + 1'b1;

  always_comb begin
    case (uw.src_a)
      SEL_X:   opa = x_r;
      SEL_Y:   opa = y_r;
      SEL_Z:   opa = z_r;
      SEL_T0:  opa = t0_r;
      SEL_T1:  opa = t1_r;
      SEL_T2:  opa = t2_r;
      SEL_T3:  opa = t3_r;
      SEL_SG:  opa = sg_v;
      SEL_RH:  opa = rh_v;
      SEL_BT:  opa = bt_v;
      SEL_DT:  opa = dt_v;
      default: opa = '0;
    endcase
    case (uw.src_b)
      SEL_X:   opb = x_r;
      SEL_Y:   opb = y_r;
      SEL_Z:   opb = z_r;
      SEL_T0:  opb = t0_r;
      SEL_T1:  opb = t1_r;
      SEL_T2:  opb = t2_r;
      SEL_T3:  opb = t3_r;
      SEL_SG:  opb = sg_v;
      SEL_RH:  opb = rh_v;
      SEL_BT:  opb = bt_v;
      SEL_DT:  opb = dt_v;
      default: opb = '0;
    endcase
  end

  // saturating add or subtract, one guard bit
  always_comb begin
    if (uw.op == OP_ADD) begin
      alu_sum = {opa[CW-1], opa} + {opb[CW-1], opb};
    end else begin
      alu_sum = {opa[CW-1], opa} - {opb[CW-1], opb};
    end
    if (alu_sum[CW] != alu_sum[CW-1]) begin
      alu_res = alu_sum[CW] ? C_MIN : C_MAX;
    end else begin
      alu_res = alu_sum[CW-1:0];
    end
  end

  assign mul_ctl.start    = (uw.op == OP_MUL) && mul_sts.idle;
  assign mul_ctl.dt_shift = uw.dt_shift;

  lei_mul #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (opa),
    .b     (opb),
    .sts   (mul_sts),
    .res   (mul_res)
  );

  always_comb begin
    adv = 1'b0;
    wr  = 1'b0;
    case (uw.op)
      OP_WAIT: adv = accept;
      OP_SUB,
      OP_ADD: begin
        adv = 1'b1;
        wr  = 1'b1;
      end
      OP_MUL: begin
        adv = mul_sts.done;
        wr  = mul_sts.done;
      end
      OP_EMIT: adv = emit_go;
      default: adv = 1'b1;
    endcase
    if (!adv) begin
      pc_nxt = pc_r;
    end else if (uw.op == OP_EMIT) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  assign wr_val = (uw.op == OP_MUL) ? mul_res : alu_res;

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    z_nxt   = z_r;
    t0_nxt  = t0_r;
    t1_nxt  = t1_r;
    t2_nxt  = t2_r;
    t3_nxt  = t3_r;
    cnt_nxt = cnt_r;
    // restart or end of run loads the start point before stepping
    if (accept && reload) begin
      x_nxt   = s0_v;
      y_nxt   = s0_v;
      z_nxt   = s0_v;
      cnt_nxt = '0;
    end
    if (wr) begin
      case (uw.dst)
        SEL_X:   x_nxt  = wr_val;
        SEL_Y:   y_nxt  = wr_val;
        SEL_Z:   z_nxt  = wr_val;
        SEL_T0:  t0_nxt = wr_val;
        SEL_T1:  t1_nxt = wr_val;
        SEL_T2:  t2_nxt = wr_val;
        SEL_T3:  t3_nxt = wr_val;
        default: begin
        end
      endcase
    end
    if (emit_go) begin
      cnt_nxt = cnt_inc;
    end
  end

  // output register, holds a word until taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {cnt_r, OUT_COORD_W'(z_r), OUT_COORD_W'(y_r), OUT_COORD_W'(x_r)};
      out_last_nxt  = (cnt_inc >= len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_WAIT;
      x_r         <= ONE_RST;
      y_r         <= ONE_RST;
      z_r         <= ONE_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      z_r         <= z_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t0_r       <= t0_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    t3_r       <= t3_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

/* hdl/lei_mul.sv */
// lorenz euler integrator: digit-serial signed multiply with floor shift and saturation
`default_nettype none
module lei_mul import lei_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 20
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire mul_ctl_t                  ctl,
  input  wire logic signed [COORD_WIDTH-1:0] a,
  input  wire logic signed [COORD_WIDTH-1:0] b,
  output mul_sts_t                       sts,
  output logic signed [COORD_WIDTH-1:0]  res
);

  localparam int NDIG  = (COORD_WIDTH + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
  localparam int MB_W  = NDIG * MUL_DIGIT_W;
  localparam int PW    = 2 * COORD_WIDTH;
  localparam int PP_W  = COORD_WIDTH + MUL_DIGIT_W;
  localparam int CNT_W = $clog2(NDIG);

  localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_RUN  = 3'b010,
    PH_FIN  = 3'b100
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [COORD_WIDTH-1:0] ma_r, ma_nxt;
  logic [MB_W-1:0]        mb_r, mb_nxt;
  logic [PW-1:0]          acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic                   sh_r, sh_nxt;

  logic [PP_W-1:0]        pp;
  logic [PW-1:0]          shifted;
  logic [PW-1:0]          q;
  logic                   rem;
  logic                   ovf;

  function automatic logic [COORD_WIDTH-1:0] mag(input logic [COORD_WIDTH-1:0] v);
    return v[COORD_WIDTH-1] ? COORD_WIDTH'(~v + 1'b1) : v;
  endfunction

  assign pp = PP_W'(ma_r) * PP_W'(mb_r[MB_W-1 -: MUL_DIGIT_W]);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    sh_nxt    = sh_r;
    case (phase_r)
      PH_IDLE: begin
        if (ctl.start) begin
          ma_nxt    = mag(a);
          mb_nxt    = MB_W'(mag(b));
          neg_nxt   = a[COORD_WIDTH-1] ^ b[COORD_WIDTH-1];
          sh_nxt    = ctl.dt_shift;
          acc_nxt   = '0;
          cnt_nxt   = CNT_W'(NDIG - 1);
          phase_nxt = PH_RUN;
        end
      end
      PH_RUN: begin
        // most significant digit first
        acc_nxt = (acc_r << MUL_DIGIT_W) + PW'(pp);
        mb_nxt  = mb_r << MUL_DIGIT_W;
        if (cnt_r == '0) begin
          phase_nxt = PH_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      PH_FIN: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // floor of a negative product: round the magnitude up
  always_comb begin
    shifted = sh_r ? (acc_r >> DT_FRAC) : (acc_r >> FRAC_BITS);
    rem     = sh_r ? (|acc_r[DT_FRAC-1:0]) : (|acc_r[FRAC_BITS-1:0]);
    q       = shifted + PW'(neg_r & rem);
    ovf     = |q[PW-1:COORD_WIDTH-1];
    if (neg_r) begin
      res = ovf ? C_MIN : COORD_WIDTH'(~q[COORD_WIDTH-1:0] + 1'b1);
    end else begin
      res = ovf ? C_MAX : q[COORD_WIDTH-1:0];
    end
  end

  assign sts.idle = (phase_r == PH_IDLE);
  assign sts.done = (phase_r == PH_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
    sh_r  <= sh_nxt;
  end

endmodule
`default_nettype wire
